// ===== hdl/rmst_pkg.sv =====
// Shared constants and types for the range-maximum segment tree.
`default_nettype none

package rmst_pkg;

   // Tree geometry
   localparam int CAPACITY   = 1024;
   localparam int VALUE_BITS = 16;
   localparam int NODE_COUNT = 2 * CAPACITY;
   localparam int NODE_W     = $clog2(NODE_COUNT);
   localparam int POS_W      = NODE_W + 1;

   // Field widths of the request and response words
   localparam int IDX_W      = 11;
   localparam int OP_W       = 2;
   localparam int MAXV_W     = 16;

   // Register file
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam logic [CSR_ADDR_W-3:0] CSR_IDX_SIZE = '0;
   localparam logic [IDX_W-1:0] SIZE_RESET = IDX_W'(CAPACITY);

   typedef enum logic [OP_W-1:0] {
      OP_CLEAR  = 2'd0,
      OP_UPDATE = 2'd1,
      OP_QUERY  = 2'd2
   } op_type;

   typedef struct packed {
      logic [IDX_W-1:0] size;
   } cfg_type;

endpackage

`default_nettype wire

// ===== hdl/rmst_csr.sv =====
// Register file: size-in-use register and its clamped value for the engine.
`default_nettype none

module rmst_csr
   import rmst_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready,
   output cfg_type                    cfg
);

   logic [IDX_W-1:0] size_ff;
   logic [IDX_W-1:0] size_in;
   logic             sel_size;

   assign sel_size = (paddr[CSR_ADDR_W-1:2] == CSR_IDX_SIZE);
   assign pready   = 1'b1;

   // Take a write in the access phase
   always_comb begin
      size_in = size_ff;
      if (psel && penable && pwrite && sel_size) begin
         size_in = pwdata[IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_RESET;
      end else begin
         size_ff <= size_in;
      end
   end

   // Return the stored value, zero elsewhere
   assign prdata = sel_size ? CSR_DATA_W'(size_ff) : '0;

   // Clamp the size to 1..CAPACITY
   always_comb begin
      if (size_ff == '0) begin
         cfg.size = IDX_W'(1);
      end else if (size_ff > IDX_W'(CAPACITY)) begin
         cfg.size = IDX_W'(CAPACITY);
      end else begin
         cfg.size = size_ff;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/rmst_engine.sv =====
// Tree engine: node memory, sequencer for clear, update and query, result register.
`default_nettype none

module rmst_engine
   import rmst_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cfg_type               cfg,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [OP_W-1:0]       req_op,
   input  wire logic [IDX_W-1:0]      req_point_index,
   input  wire logic [MAXV_W-1:0]     req_new_value,
   input  wire logic [IDX_W-1:0]      req_range_low,
   input  wire logic [IDX_W-1:0]      req_range_high,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic      [MAXV_W-1:0]     rsp_max_value,
   output logic                       rsp_status
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_DECODE = 6'b000010,
      ST_SWEEP  = 6'b000100,
      ST_UPD    = 6'b001000,
      ST_QRY    = 6'b010000,
      ST_DONE   = 6'b100000
   } state_type;

   function automatic logic [VALUE_BITS-1:0] vmax(input logic [VALUE_BITS-1:0] a,
                                                  input logic [VALUE_BITS-1:0] b);
      return (a > b) ? a : b;
   endfunction

   // Node memory and its registered read ports
   logic [VALUE_BITS-1:0] node_mem_ff [NODE_COUNT];
   logic [VALUE_BITS-1:0] rd_a_ff;
   logic [VALUE_BITS-1:0] rd_b_ff;
   logic                  mem_we;
   logic [NODE_W-1:0]     mem_wa;
   logic [VALUE_BITS-1:0] mem_wd;
   logic [NODE_W-1:0]     mem_ra;
   logic [NODE_W-1:0]     mem_rb;

   // Control state
   state_type             state_ff,      state_in;
   logic [NODE_W-1:0]     sweep_ff,      sweep_in;
   logic [NODE_W-1:0]     sweep_end_ff,  sweep_end_in;
   logic                  clr_rsp_ff,    clr_rsp_in;
   logic                  take_a_ff,     take_a_in;
   logic                  take_b_ff,     take_b_in;
   logic                  rsp_valid_ff,  rsp_valid_in;

   // Payload and working registers
   op_type                op_ff,         op_in;
   logic [IDX_W-1:0]      pidx_ff,       pidx_in;
   logic [VALUE_BITS-1:0] nval_ff,       nval_in;
   logic [IDX_W-1:0]      lo_ff,         lo_in;
   logic [IDX_W-1:0]      hi_ff,         hi_in;
   logic [NODE_W-1:0]     x_ff,          x_in;
   logic [VALUE_BITS-1:0] cur_ff,        cur_in;
   logic [POS_W-1:0]      l_ff,          l_in;
   logic [POS_W-1:0]      r_ff,          r_in;
   logic [VALUE_BITS-1:0] acc_ff,        acc_in;
   logic [VALUE_BITS-1:0] res_val_ff,    res_val_in;
   logic                  res_st_ff,     res_st_in;
   logic [MAXV_W-1:0]     rsp_max_ff,    rsp_max_in;
   logic                  rsp_st_ff,     rsp_st_in;

   // Decode helpers
   logic [NODE_W-1:0]     leaf;
   logic [NODE_W-1:0]     parent;
   logic [POS_W-1:0]      r_dec;
   logic [VALUE_BITS-1:0] pick;
   logic                  rsp_free;

   assign leaf     = NODE_W'(POS_W'(cfg.size) + POS_W'(pidx_ff) - POS_W'(1));
   assign parent   = x_ff >> 1;
   assign r_dec    = r_ff - POS_W'(1);
   assign pick     = vmax(take_a_ff ? rd_a_ff : '0, take_b_ff ? rd_b_ff : '0);
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   assign req_ready     = (state_ff == ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_max_value = rsp_max_ff;
   assign rsp_status    = rsp_st_ff;

   always_comb begin
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      sweep_end_in = sweep_end_ff;
      clr_rsp_in   = clr_rsp_ff;
      take_a_in    = 1'b0;
      take_b_in    = 1'b0;
      op_in        = op_ff;
      pidx_in      = pidx_ff;
      nval_in      = nval_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      x_in         = x_ff;
      cur_in       = cur_ff;
      l_in         = l_ff;
      r_in         = r_ff;
      acc_in       = acc_ff;
      res_val_in   = res_val_ff;
      res_st_in    = res_st_ff;
      rsp_max_in   = rsp_max_ff;
      rsp_st_in    = rsp_st_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      mem_we       = 1'b0;
      mem_wa       = sweep_ff;
      mem_wd       = '0;
      mem_ra       = l_ff[NODE_W-1:0];
      mem_rb       = r_dec[NODE_W-1:0];

      case (state_ff)
         // Capture the request word
         ST_IDLE: begin
            if (req_valid) begin
               op_in    = op_type'(req_op);
               pidx_in  = req_point_index;
               nval_in  = VALUE_BITS'(req_new_value);
               lo_in    = req_range_low;
               hi_in    = req_range_high;
               state_in = ST_DECODE;
            end
         end

         // Check positions and set up the walk
         ST_DECODE: begin
            res_val_in = '0;
            res_st_in  = 1'b0;
            case (op_ff)
               OP_CLEAR: begin
                  sweep_in     = '0;
                  sweep_end_in = NODE_W'({cfg.size, 1'b0} - 1);
                  clr_rsp_in   = 1'b1;
                  state_in     = ST_SWEEP;
               end
               OP_UPDATE: begin
                  if (pidx_ff == '0 || pidx_ff > cfg.size) begin
                     res_st_in = 1'b1;
                     state_in  = ST_DONE;
                  end else begin
                     mem_we = 1'b1;
                     mem_wa = leaf;
                     mem_wd = nval_ff;
                     mem_ra = leaf ^ NODE_W'(1);
                     x_in   = leaf;
                     cur_in = nval_ff;
                     state_in = (leaf > NODE_W'(1)) ? ST_UPD : ST_DONE;
                  end
               end
               OP_QUERY: begin
                  if (lo_ff == '0 || lo_ff > cfg.size || hi_ff > cfg.size) begin
                     res_st_in = 1'b1;
                     state_in  = ST_DONE;
                  end else if (hi_ff < lo_ff) begin
                     state_in = ST_DONE;
                  end else begin
                     l_in     = POS_W'(lo_ff) - POS_W'(1) + POS_W'(cfg.size);
                     r_in     = POS_W'(hi_ff) + POS_W'(cfg.size);
                     acc_in   = '0;
                     state_in = ST_QRY;
                  end
               end
               default: begin
                  res_st_in = 1'b1;
                  state_in  = ST_DONE;
               end
            endcase
         end

         // Zero one node a cycle
         ST_SWEEP: begin
            mem_we   = 1'b1;
            mem_wa   = sweep_ff;
            mem_wd   = '0;
            sweep_in = sweep_ff + NODE_W'(1);
            if (sweep_ff == sweep_end_ff) begin
               state_in = clr_rsp_ff ? ST_DONE : ST_IDLE;
            end
         end

         // Write the parent from the carried value and the sibling just read
         ST_UPD: begin
            mem_we = 1'b1;
            mem_wa = parent;
            mem_wd = vmax(cur_ff, rd_a_ff);
            mem_ra = parent ^ NODE_W'(1);
            cur_in = vmax(cur_ff, rd_a_ff);
            x_in   = parent;
            if (parent <= NODE_W'(1)) begin
               state_in = ST_DONE;
            end
         end

         // Issue the border reads of a level and fold in the previous level
         ST_QRY: begin
            acc_in = vmax(acc_ff, pick);
            if (l_ff < r_ff) begin
               mem_ra    = l_ff[NODE_W-1:0];
               mem_rb    = r_dec[NODE_W-1:0];
               take_a_in = l_ff[0];
               take_b_in = r_ff[0];
               l_in      = (l_ff + POS_W'(l_ff[0])) >> 1;
               r_in      = (r_ff - POS_W'(r_ff[0])) >> 1;
            end else begin
               res_val_in = vmax(acc_ff, pick);
               state_in   = ST_DONE;
            end
         end

         // Hand the result to the output register once it is free
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_max_in   = MAXV_W'(res_val_ff);
               rsp_st_in    = res_st_ff;
               clr_rsp_in   = 1'b0;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers; reset starts a sweep over the whole memory
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         sweep_ff     <= '0;
         sweep_end_ff <= NODE_W'(NODE_COUNT - 1);
         clr_rsp_ff   <= 1'b0;
         take_a_ff    <= 1'b0;
         take_b_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         sweep_end_ff <= sweep_end_in;
         clr_rsp_ff   <= clr_rsp_in;
         take_a_ff    <= take_a_in;
         take_b_ff    <= take_b_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and working registers
   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      pidx_ff    <= pidx_in;
      nval_ff    <= nval_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      x_ff       <= x_in;
      cur_ff     <= cur_in;
      l_ff       <= l_in;
      r_ff       <= r_in;
      acc_ff     <= acc_in;
      res_val_ff <= res_val_in;
      res_st_ff  <= res_st_in;
      rsp_max_ff <= rsp_max_in;
      rsp_st_ff  <= rsp_st_in;
   end

   // Node memory: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (mem_we) begin
         node_mem_ff[mem_wa] <= mem_wd;
      end
      rd_a_ff <= node_mem_ff[mem_ra];
      rd_b_ff <= node_mem_ff[mem_rb];
   end

   // An update never reads the node it writes in the same cycle
   a_upd_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPD) |-> (mem_wa != mem_ra))
      else $error("update writes and reads the same node");

   // The walk towards the root stays above the root
   a_upd_above_root: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPD) |-> (x_ff > NODE_W'(1)))
      else $error("update walk past the root");

   // Query borders never cross
   a_qry_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_QRY) |-> (l_ff <= r_ff))
      else $error("query borders crossed");

   // A response appears only after the result state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("response loaded outside the result state");

endmodule

`default_nettype wire

// ===== hdl/range_max_segment_tree_top.sv =====
// Range-maximum segment tree: request and response channels with an APB-style register port.
//
// Each request word carries one operation: clear, point update or range-maximum query,
// and yields exactly one response word. An update walks from the leaf to the root and
// a query walks the tree level by level through the node memory (a sibling read and a
// parent write per level for update, two border reads per level for query). A clear
// zeroes nodes 0 to 2*size-1, one node per cycle through the memory write port. After
// reset the block sweeps all 2048 nodes to zero and accepts no request in that time;
// register writes are taken throughout. A finished response waits in its output
// register while the next request is taken. Issue a clear after changing size.
`default_nettype none

module range_max_segment_tree_top
   import rmst_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [OP_W-1:0]       req_op,
   input  wire logic [IDX_W-1:0]      req_point_index,
   input  wire logic [MAXV_W-1:0]     req_new_value,
   input  wire logic [IDX_W-1:0]      req_range_low,
   input  wire logic [IDX_W-1:0]      req_range_high,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic      [MAXV_W-1:0]     rsp_max_value,
   output logic                       rsp_status,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready
);

   cfg_type cfg;

   rmst_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   rmst_engine u_engine (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_point_index (req_point_index),
      .req_new_value   (req_new_value),
      .req_range_low   (req_range_low),
      .req_range_high  (req_range_high),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_max_value   (rsp_max_value),
      .rsp_status      (rsp_status)
   );

endmodule

`default_nettype wire
